// ===== design/signed_integer_to_decimal_ascii_macros.svh =====
// Assertion macros used by the converter RTL.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SITDA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sitda check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SITDA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sitda check failed");

`endif

// ===== design/sitda_pkg.sv =====
package sitda_pkg;

	// ASCII codes, six bits wide
	localparam logic [5:0] CH_ZERO  = 6'd48;
	localparam logic [5:0] CH_MINUS = 6'd45;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_DIGS = 4'b1000
	} state_t;

	// operations on the BCD digit register
	typedef enum logic [1:0] {
		BCD_HOLD,
		BCD_CLEAR,
		BCD_DABBLE,
		BCD_DSHIFT
	} bcd_op_t;

	typedef struct packed {
		bcd_op_t op;
		logic    bit_in;
	} bcd_ctrl_t;

endpackage

// ===== design/signed_integer_to_decimal_ascii.sv =====
// After start, the magnitude is shifted bit-serially through double dabble into the
// digit register, one bit per cycle; then the characters follow, one per cycle, and
// a leading zero digit is not emitted but leaves a gap with strobe low.
// A new request is accepted only in idle, once the previous one has finished.
// Every character is strobed for one cycle; the receiver cannot stall.
// Reset clears the controller at once; busy is low after reset.
`include "signed_integer_to_decimal_ascii_macros.svh"

module signed_integer_to_decimal_ascii
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  strobe,
	output logic [5:0]            character,
	output logic                  last
);

	localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int CW   = $clog2(VALUE_BITS + 1);

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic                  seen_q;
	logic [CW-1:0]         cnt_q;
	logic                  strobe_q;
	logic [5:0]            character_q;
	logic                  last_q;
	bcd_ctrl_t             bctl;
	logic [3:0]            top_digit;
	logic                  last_dig;
	logic                  emit;

	sitda_bcd #(.NDIG(NDIG)) u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (bctl),
		.top_digit (top_digit)
	);

	assign last_dig = (cnt_q == CW'(1));
	assign emit     = seen_q || (top_digit != 4'd0) || last_dig;

	// drive the digit register from the state
	always_comb begin
		bctl.bit_in = mag_q[VALUE_BITS-1];
		unique case (state_q)
			ST_IDLE: bctl.op = (start) ? BCD_CLEAR : BCD_HOLD;
			ST_CONV: bctl.op = BCD_DABBLE;
			ST_SIGN: bctl.op = BCD_HOLD;
			ST_DIGS: bctl.op = BCD_DSHIFT;
			default: bctl.op = BCD_HOLD;
		endcase
	end

	// sequence: convert, sign if negative, digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			seen_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q   <= value[VALUE_BITS-1];
						seen_q  <= 1'b0;
						cnt_q   <= CW'(VALUE_BITS - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(NDIG);
						state_q <= (neg_q) ? ST_SIGN : ST_DIGS;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGS;
				end
				ST_DIGS: begin
					strobe_q <= emit;
					if (emit) begin
						seen_q <= 1'b1;
					end
					cnt_q <= cnt_q - CW'(1);
					if (last_dig) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the magnitude, then shift it out MSB first
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mag_q <= (value[VALUE_BITS-1]) ? (~value + VALUE_BITS'(1)) : value;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// hold the character for its one cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN) begin
			character_q <= CH_MINUS;
			last_q      <= 1'b0;
		end else begin
			character_q <= CH_ZERO + {2'b00, top_digit};
			last_q      <= last_dig;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

	`SITDA_ASSERT_NOW(a_last_ends_request, strobe && last, state_q == ST_IDLE)
	`SITDA_ASSERT_NEXT(a_accept_no_strobe, start && !busy, busy && !strobe)
	`SITDA_ASSERT_NOW(a_minus_not_last, strobe && character == CH_MINUS, !last)
	`SITDA_ASSERT_NEXT(a_final_digit_out, state_q == ST_DIGS && last_dig, strobe && last)

endmodule

// ===== design/sitda_bcd.sv =====
module sitda_bcd
	import sitda_pkg::*;
#(
	parameter int NDIG = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  bcd_ctrl_t ctrl,
	output logic [3:0] top_digit
);

	logic [4*NDIG-1:0] bcd_q;
	logic [4*NDIG-1:0] adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// clear, hold, shift one binary bit in, or shift one digit out at the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
		end else begin
			unique case (ctrl.op)
				BCD_HOLD:   bcd_q <= bcd_q;
				BCD_CLEAR:  bcd_q <= '0;
				BCD_DABBLE: bcd_q <= {adj[4*NDIG-2:0], ctrl.bit_in};
				BCD_DSHIFT: bcd_q <= {bcd_q[4*NDIG-5:0], 4'd0};
				default:    bcd_q <= bcd_q;
			endcase
		end
	end

	assign top_digit = bcd_q[4*NDIG-1 -: 4];

endmodule
